/* hw/rtl/rrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and codes of the record ring queue: opcodes, status codes,
// field widths and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int OP_W     = 3;
  localparam int NAME_W   = 64;
  localparam int YEAR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic                latch;     // capture the input word
    logic                wr_push;   // write record at tail, advance tail
    logic                head_adv;  // advance head
    logic                clear;     // both pointers to zero
    logic                ptr_load;  // walk pointer from head
    logic                ptr_step;  // walk pointer to next entry
    logic                rd_ptr;    // read at walk pointer instead of head
    logic                emit;      // load the output register
    logic                emit_rec;  // result carries the record read
    logic [STATUS_W-1:0] emit_st;
    logic                emit_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            match;
    logic            ptr_last;
    logic            out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/rrq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_in_if / rrq_out_if
// Valid/ready channels of the record ring queue: operation words in,
// result words out.
// ----------------------------------------------------------------------------
interface rrq_in_if import rrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NAME_W-1:0] first_name;
  logic [NAME_W-1:0] surname;
  logic [YEAR_W-1:0] birth_year;

  modport source (output valid, opcode, first_name, surname, birth_year, input ready);
  modport sink   (input valid, opcode, first_name, surname, birth_year, output ready);
endinterface

interface rrq_out_if import rrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NAME_W-1:0]   out_first_name;
  logic [NAME_W-1:0]   out_surname;
  logic [YEAR_W-1:0]   out_birth_year;
  logic [COUNT_W-1:0]  entry_count;
  logic                last;

  modport source (output valid, status, out_first_name, out_surname, out_birth_year,
                  entry_count, last, input ready);
  modport sink   (input valid, status, out_first_name, out_surname, out_birth_year,
                  entry_count, last, output ready);
endinterface

/* hw/rtl/record_ring_queue_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_ring_queue_with_search
// Circular queue of name/surname/birth-year records with push, pop,
// surname search, list, count and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word (opcode, first_name, surname, birth_year);
//   rsp returns result words (status, record fields, entry_count, last).
//   Every operation yields one result word with last set, except list of a
//   non-empty queue: one word per held record, front to rear, last on the final one.
//   The queue holds at most DEPTH-1 records; only the low NAME_BITS bits of
//   each name are stored and compared.
// Timing:
//   One operation at a time. req.ready is high only while idle. Push, count
//   and clear emit their result from the execute state, pop from the pop
//   state that follows it. Search and list read the record memory (registered
//   read) one entry per cycle, list giving one word per cycle when rsp is taken.
// Reset and stalls:
//   rst (synchronous) empties the queue and drops any pending result. A
//   stalled rsp holds the current word; the walk waits on it, nothing is lost.
// ----------------------------------------------------------------------------
module record_ring_queue_with_search import rrq_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int NAME_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  rrq_in_if.sink    req,
  rrq_out_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      ready;

  assign req.ready = ready;

  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrq_dp #(
    .DEPTH     (DEPTH),
    .NAME_BITS (NAME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (req.opcode),
    .in_first_name  (req.first_name),
    .in_surname     (req.surname),
    .in_birth_year  (req.birth_year),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_first_name (rsp.out_first_name),
    .out_surname    (rsp.out_surname),
    .out_birth_year (rsp.out_birth_year),
    .out_count      (rsp.entry_count),
    .out_last       (rsp.last)
  );

endmodule

/* hw/rtl/rrq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ctrl
// Operation sequencer: takes one word, runs push, pop, walk or housekeeping
// and schedules each result into the output register.
// ----------------------------------------------------------------------------
module rrq_ctrl import rrq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.emit_st   = ST_OK;
    cmd.emit_last = 1'b1;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_PUSH: begin
            if (sts.out_free) begin
              cmd.emit    = 1'b1;
              cmd.emit_st = sts.full ? ST_FULL : ST_OK;
              cmd.wr_push = !sts.full;
              state_next  = S_IDLE;
            end
          end
          OP_POP: begin
            if (!sts.empty) begin
              state_next = S_POP;
            end else if (sts.out_free) begin
              cmd.emit    = 1'b1;
              cmd.emit_st = ST_EMPTY;
              state_next  = S_IDLE;
            end
          end
          OP_SEARCH, OP_LIST: begin
            if (!sts.empty) begin
              cmd.ptr_load = 1'b1;
              state_next   = S_WALK;
            end else if (sts.out_free) begin
              cmd.emit    = 1'b1;
              cmd.emit_st = ST_EMPTY;
              state_next  = S_IDLE;
            end
          end
          OP_CLEAR: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.clear  = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_rec = 1'b1;
          cmd.head_adv = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.rd_ptr = 1'b1;
        if (sts.op == OP_SEARCH) begin
          if (sts.match) begin
            if (sts.out_free) begin
              cmd.emit     = 1'b1;
              cmd.emit_rec = 1'b1;
              state_next   = S_IDLE;
            end
          end else if (sts.ptr_last) begin
            if (sts.out_free) begin
              cmd.emit    = 1'b1;
              cmd.emit_st = ST_NOT_FOUND;
              state_next  = S_IDLE;
            end
          end else begin
            cmd.ptr_step = 1'b1;
          end
        end else if (sts.out_free) begin
          // list: one result per entry, hold while the receiver stalls
          cmd.emit      = 1'b1;
          cmd.emit_rec  = 1'b1;
          cmd.emit_last = sts.ptr_last;
          if (sts.ptr_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/rrq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_dp
// Queue datapath: record memory, head/tail/walk pointers, captured operation
// word, surname compare and the output register.
// ----------------------------------------------------------------------------
module rrq_dp import rrq_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int NAME_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [NAME_W-1:0]   in_first_name,
  input  logic [NAME_W-1:0]   in_surname,
  input  logic [YEAR_W-1:0]   in_birth_year,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [NAME_W-1:0]   out_first_name,
  output logic [NAME_W-1:0]   out_surname,
  output logic [YEAR_W-1:0]   out_birth_year,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_last
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = 2 * NAME_BITS + YEAR_W;
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW:0] held(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [PW:0] he, te;
    he = {1'b0, h};
    te = {1'b0, t};
    return (te >= he) ? (te - he) : (te + DEPTH_W - he);
  endfunction

  logic [RW-1:0]     mem [DEPTH];
  logic [RW-1:0]     rd_data;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     head, tail, ptr;
  logic [PW-1:0]     head_next, tail_next;
  logic [OP_W-1:0]   op;
  logic [NAME_W-1:0] first_q, sur_q;
  logic [YEAR_W-1:0] year_q;
  logic [NAME_BITS-1:0] rd_first, rd_sur;
  logic [YEAR_W-1:0]    rd_year;
  logic              full;

  assign rd_first = rd_data[RW-1 -: NAME_BITS];
  assign rd_sur   = rd_data[YEAR_W +: NAME_BITS];
  assign rd_year  = rd_data[YEAR_W-1:0];
  assign full     = (adv(tail) == head);

  assign sts.op       = op;
  assign sts.empty    = (head == tail);
  assign sts.full     = full;
  assign sts.match    = (rd_sur == sur_q[NAME_BITS-1:0]);
  assign sts.ptr_last = (adv(ptr) == tail);
  assign sts.out_free = !out_valid || out_ready;

  // walk reads one entry ahead when it steps
  always_comb begin
    if (cmd.rd_ptr) begin
      rd_addr = cmd.ptr_step ? adv(ptr) : ptr;
    end else begin
      rd_addr = head;
    end
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (cmd.clear) begin
      head_next = '0;
      tail_next = '0;
    end else begin
      if (cmd.head_adv) head_next = adv(head);
      if (cmd.wr_push)  tail_next = adv(tail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_load) begin
      ptr <= head;
    end else if (cmd.ptr_step) begin
      ptr <= adv(ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op      <= in_opcode;
      first_q <= in_first_name;
      sur_q   <= in_surname;
      year_q  <= in_birth_year;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_push) begin
      mem[tail] <= {first_q[NAME_BITS-1:0], sur_q[NAME_BITS-1:0], year_q};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status     <= cmd.emit_st;
      out_first_name <= cmd.emit_rec ? NAME_W'(rd_first) : '0;
      out_surname    <= cmd.emit_rec ? NAME_W'(rd_sur) : '0;
      out_birth_year <= cmd.emit_rec ? rd_year : '0;
      out_count      <= COUNT_W'(held(head_next, tail_next));
      out_last       <= cmd.emit_last;
    end
  end

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken word");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_push |-> !full)
    else $error("push written into a full queue");

  a_step_not_past_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.ptr_step |-> (adv(ptr) != tail))
    else $error("walk stepped past the rear");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head <= LAST_IDX) && (tail <= LAST_IDX))
    else $error("pointer out of range");
`endif

endmodule

/* tb/sv/record_ring_queue_with_search_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_ring_queue_with_search_test
// Self-checking bench for the record ring queue. An initial block queues up
// operation words: a directed opening, then a fill past full, random traffic,
// a drain and more random traffic. A bursty driver sends them and a stalling
// sink takes the result words. Every accepted operation runs through a
// behavioral copy of the ring, and each result word is checked in order
// against the words that the copy predicts.
// ----------------------------------------------------------------------------
module record_ring_queue_with_search_test;
  import rrq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int NAME_BITS   = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_OPS  = 220;

  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - NAME_BITS);
  localparam logic [NAME_W-1:0] ALL_ONES  = {NAME_W{1'b1}};

  // opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NAME_W-1:0] first_name;
    logic [NAME_W-1:0] surname;
    logic [YEAR_W-1:0] birth_year;
  } op_word_t;

  typedef struct packed {
    logic [NAME_W-1:0] first_name;
    logic [NAME_W-1:0] surname;
    logic [YEAR_W-1:0] birth_year;
  } person_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NAME_W-1:0]   first_name;
    logic [NAME_W-1:0]   surname;
    logic [YEAR_W-1:0]   birth_year;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } result_t;

  typedef enum logic [1:0] {SINK_STEADY, SINK_COIN, SINK_SPARSE, SINK_BURSTY} sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  rrq_in_if  req_if ();
  rrq_out_if rsp_if ();

  record_ring_queue_with_search #(
    .DEPTH     (DEPTH),
    .NAME_BITS (NAME_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- ring copy
  person_t     ring_rec [DEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  result_t     expected_results [$];

  int unsigned n_full, n_empty, n_not_found, n_hits, peak_held;

  function automatic int unsigned held();
    return (ring_tail + DEPTH - ring_head) % DEPTH;
  endfunction

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  function automatic void expect_word(logic [STATUS_W-1:0] st, person_t r, logic fin);
    result_t w;
    w.status      = st;
    w.first_name  = r.first_name;
    w.surname     = r.surname;
    w.birth_year  = r.birth_year;
    w.entry_count = COUNT_W'(held());
    w.last        = fin;
    expected_results.push_back(w);
    if (held() > peak_held) peak_held = held();
    case (st)
      ST_FULL:      n_full++;
      ST_EMPTY:     n_empty++;
      ST_NOT_FOUND: n_not_found++;
      default: ;
    endcase
  endfunction

  function automatic void predict_results(op_word_t w);
    person_t     none;
    int unsigned p;
    logic        found;
    none  = '0;
    found = 1'b0;
    case (w.opcode)
      OP_PUSH: begin
        if (next_slot(ring_tail) == ring_head) begin
          expect_word(ST_FULL, none, 1'b1);
        end else begin
          ring_rec[ring_tail].first_name = w.first_name & NAME_MASK;
          ring_rec[ring_tail].surname    = w.surname & NAME_MASK;
          ring_rec[ring_tail].birth_year = w.birth_year;
          ring_tail = next_slot(ring_tail);
          expect_word(ST_OK, none, 1'b1);
        end
      end
      OP_POP: begin
        if (ring_head == ring_tail) begin
          expect_word(ST_EMPTY, none, 1'b1);
        end else begin
          p = ring_head;
          ring_head = next_slot(ring_head);
          expect_word(ST_OK, ring_rec[p], 1'b1);
        end
      end
      OP_SEARCH: begin
        if (ring_head == ring_tail) begin
          expect_word(ST_EMPTY, none, 1'b1);
        end else begin
          // first match from front to rear wins
          for (p = ring_head; p != ring_tail && !found; p = next_slot(p)) begin
            if (ring_rec[p].surname == (w.surname & NAME_MASK)) begin
              expect_word(ST_OK, ring_rec[p], 1'b1);
              found = 1'b1;
              n_hits++;
            end
          end
          if (!found) expect_word(ST_NOT_FOUND, none, 1'b1);
        end
      end
      OP_LIST: begin
        if (ring_head == ring_tail) begin
          expect_word(ST_EMPTY, none, 1'b1);
        end else begin
          for (p = ring_head; p != ring_tail; p = next_slot(p))
            expect_word(ST_OK, ring_rec[p], next_slot(p) == ring_tail);
        end
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        expect_word(ST_OK, none, 1'b1);
      end
      default: expect_word(ST_OK, none, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  op_word_t          pending_words [$];
  logic [NAME_W-1:0] recent_surnames [$];
  logic [NAME_W-1:0] name_pool [4];
  int unsigned       fill_est;

  function automatic void add_word(logic [OP_W-1:0] op, logic [NAME_W-1:0] f,
                                   logic [NAME_W-1:0] s, logic [YEAR_W-1:0] y);
    op_word_t w;
    w = '{op, f, s, y};
    pending_words.push_back(w);
    case (op)
      OP_PUSH: begin
        if (fill_est < DEPTH - 1) fill_est++;
        recent_surnames.push_back(s);
        if (recent_surnames.size() > 40) void'(recent_surnames.pop_front());
      end
      OP_POP:   if (fill_est > 0) fill_est--;
      OP_CLEAR: fill_est = 0;
      default: ;
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] random_name();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3:    return name_pool[$urandom_range(0, 3)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [YEAR_W-1:0] random_year();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return YEAR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] search_key();
    if (recent_surnames.size() > 0 && $urandom_range(0, 9) < 6)
      return recent_surnames[$urandom_range(0, recent_surnames.size() - 1)];
    return random_name();
  endfunction

  function automatic void add_random_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      add_word(OP_PUSH, random_name(), random_name(), random_year());
    else if (r < push_pct + 22)
      add_word(OP_POP, random_name(), random_name(), random_year());
    else if (r < push_pct + 37)
      add_word(OP_SEARCH, random_name(), search_key(), random_year());
    else if (r < push_pct + 42)
      add_word(OP_LIST, random_name(), random_name(), random_year());
    else if (r < push_pct + 47)
      add_word(OP_COUNT, random_name(), random_name(), random_year());
    else if (r < push_pct + 50)
      add_word(OP_CLEAR, random_name(), random_name(), random_year());
    else
      add_word($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B,
               random_name(), random_name(), random_year());
  endfunction

  // ---------------------------------------------------------------- driver
  op_word_t    on_bus;
  int unsigned burst_left, gap_left, words_accepted;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid      <= 1'b0;
      req_if.opcode     <= '0;
      req_if.first_name <= '0;
      req_if.surname    <= '0;
      req_if.birth_year <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_results(on_bus);
        words_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          on_bus = pending_words.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= on_bus.opcode;
          req_if.first_name <= on_bus.first_name;
          req_if.surname    <= on_bus.surname;
          req_if.birth_year <= on_bus.birth_year;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // end of burst: pick the next burst and the gap before it
            burst_left = $urandom_range(0, 7);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  sink_mode_t  sink_mode;
  int unsigned mode_left, stall_left, results_checked, errors;

  task automatic report_mismatch(string what, result_t want, result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%t %s: exp st=%0d fn=%h sn=%h yr=%0d cnt=%0d last=%0b",
               $realtime, what, want.status, want.first_name, want.surname,
               want.birth_year, want.entry_count, want.last);
      $display("%t %s: got st=%0d fn=%h sn=%h yr=%0d cnt=%0d last=%0b",
               $realtime, what, got.status, got.first_name, got.surname,
               got.birth_year, got.entry_count, got.last);
    end
  endtask

  task automatic check_result();
    result_t got, want;
    got = '{rsp_if.status, rsp_if.out_first_name, rsp_if.out_surname,
            rsp_if.out_birth_year, rsp_if.entry_count, rsp_if.last};
    results_checked++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result word", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.first_name !== want.first_name ||
          got.surname !== want.surname || got.birth_year !== want.birth_year ||
          got.entry_count !== want.entry_count || got.last !== want.last)
        report_mismatch("result word mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      mode_left  = 0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_result();
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_STEADY: rsp_if.ready <= 1'b1;
        SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned cycles;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    fill_est  = 0;
    name_pool = '{64'h0000_0000_0000_4B41, 64'h0000_004E_4F57_4F4B,
                  64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF};

    // directed: empty cases, no-op codes, field extremes, first match
    add_word(OP_POP,    '0, '0, '0);
    add_word(OP_SEARCH, '0, '0, '0);
    add_word(OP_LIST,   '0, '0, '0);
    add_word(OP_COUNT,  '0, '0, '0);
    add_word(OP_RSVD_A, ALL_ONES, ALL_ONES, '1);
    add_word(OP_RSVD_B, ALL_ONES, ALL_ONES, '1);
    add_word(OP_PUSH,   '0, '0, '0);
    add_word(OP_PUSH,   ALL_ONES, ALL_ONES, '1);
    add_word(OP_PUSH,   64'hAAAA_AAAA_AAAA_AAAA, name_pool[1], 16'd1987);
    add_word(OP_PUSH,   64'h5555_5555_5555_5555, name_pool[1], 16'd2001);
    add_word(OP_SEARCH, '0, ALL_ONES, '0);
    add_word(OP_SEARCH, '0, name_pool[1], '0);
    add_word(OP_SEARCH, '0, name_pool[2], '0);
    add_word(OP_LIST,   '0, '0, '0);
    add_word(OP_COUNT,  ALL_ONES, ALL_ONES, '1);
    add_word(OP_POP,    '0, '0, '0);
    add_word(OP_SEARCH, '0, '0, '0);
    add_word(OP_CLEAR,  '0, '0, '0);
    add_word(OP_LIST,   '0, '0, '0);
    add_word(OP_PUSH,   name_pool[3], name_pool[0], 16'd1);
    add_word(OP_POP,    '0, '0, '0);
    add_word(OP_POP,    '0, '0, '0);

    // fill past full from a nonzero head so the pointers wrap
    repeat (DEPTH + 2) add_word(OP_PUSH, random_name(), random_name(), random_year());
    add_word(OP_LIST,   random_name(), random_name(), random_year());
    add_word(OP_SEARCH, random_name(), search_key(), random_year());
    add_word(OP_SEARCH, random_name(), random_name(), random_year());
    add_word(OP_COUNT,  random_name(), random_name(), random_year());
    repeat (60) add_random_op(45);
    // drain to empty, then one pop and one list too many
    while (fill_est > 0) add_word(OP_POP, random_name(), random_name(), random_year());
    add_word(OP_POP,  random_name(), random_name(), random_year());
    add_word(OP_LIST, random_name(), random_name(), random_year());
    while (pending_words.size() < RANDOM_OPS) add_random_op(55);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(negedge clk);
    // let any stray trailing word show up
    repeat (40) @(negedge clk);

    $display("ran %0d operation words and checked %0d result words in %0d cycles",
             words_accepted, results_checked, cycles);
    $display("peak of %0d records; %0d full, %0d empty, %0d not found, %0d search hits",
             peak_held, n_full, n_empty, n_not_found, n_hits);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
